// ===== rtl/core/date_add_days_unit_defines.svh =====
// Assertion macros for the date_add_days_unit checker.
// Each macro expects a signal named clk, and all but DAD_ASSERT_RESET also rst, in the scope where it is used.
`ifndef DATE_ADD_DAYS_UNIT_DEFINES_SVH
`define DATE_ADD_DAYS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DAD_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("date_add_days_unit: check failed");

// Next-cycle implication, disabled while reset is high.
`define DAD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("date_add_days_unit: check failed");

// Next-cycle implication that is also checked across reset.
`define DAD_ASSERT_RESET(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("date_add_days_unit: reset check failed");

`endif

// ===== rtl/core/dad_pkg.sv =====
// Package for the date_add_days_unit block: widths, calendar constants,
// state type, structs and calendar helper functions. No dependencies.
package dad_pkg;

  localparam int OFFSET_BITS = 17;
  localparam int YEAR_W      = 14;
  localparam int MONTH_W     = 4;
  localparam int DAY_W       = 5;

  // Day accumulator: holds day plus offset and one year length either way.
  localparam int ACC_W = (OFFSET_BITS + 2 > YEAR_W + 1) ? OFFSET_BITS + 2 : YEAR_W + 1;
  // Working year: input range plus the years that the largest offset spans.
  localparam int WY_W  = ((OFFSET_BITS - 8 > YEAR_W) ? OFFSET_BITS - 8 : YEAR_W) + 1;
  localparam int Y400_W = 9;

  localparam int YEAR_MIN     = 1;
  localparam int YEAR_MAX     = 9999;
  localparam int MONTHS       = 12;
  localparam int CYCLE_YEARS  = 400;
  localparam int SHORT_YEAR   = 365;
  localparam int LONG_YEAR    = 366;
  localparam int FEB_SHORT    = 28;
  localparam int FEB_LEAP     = 29;
  localparam int SHORT_MONTH  = 30;
  localparam int LONG_MONTH   = 31;
  localparam int FEBRUARY     = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_WALK,
    ST_HOLD
  } dad_state_t;

  typedef struct packed {
    logic [YEAR_W-1:0]      year;
    logic [MONTH_W-1:0]     month;
    logic [DAY_W-1:0]       day;
    logic [OFFSET_BITS-1:0] offset;
  } dad_req_t;

  typedef struct packed {
    logic [WY_W-1:0]    year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } dad_res_t;

  typedef struct packed {
    logic start;
    logic out_free;
  } dad_cmd_t;

  typedef struct packed {
    logic idle;
    logic done;
  } dad_ctl_t;

  typedef struct packed {
    logic plus;
    logic neg;
  } dad_flags_t;

  function automatic logic is_leap(input logic [Y400_W-1:0] y400);
    logic century;
    century = (y400 == Y400_W'(100)) || (y400 == Y400_W'(200)) ||
              (y400 == Y400_W'(300));
    return (y400[1:0] == 2'd0) && !century;
  endfunction

  function automatic logic [Y400_W-1:0] cyc_inc(input logic [Y400_W-1:0] y400);
    return (y400 == Y400_W'(CYCLE_YEARS - 1)) ? '0 : y400 + Y400_W'(1);
  endfunction

  function automatic logic [Y400_W-1:0] cyc_dec(input logic [Y400_W-1:0] y400);
    return (y400 == '0) ? Y400_W'(CYCLE_YEARS - 1) : y400 - Y400_W'(1);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      MONTH_W'(FEBRUARY): len = leap ? DAY_W'(FEB_LEAP) : DAY_W'(FEB_SHORT);
      MONTH_W'(4), MONTH_W'(6), MONTH_W'(9), MONTH_W'(11): len = DAY_W'(SHORT_MONTH);
      default: len = DAY_W'(LONG_MONTH);
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/dad_in_if.sv =====
// Input channel of date_add_days_unit: valid/ready plus the base date and offset.
// Depends on dad_pkg.
interface dad_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [dad_pkg::YEAR_W-1:0]           start_year;
  logic [dad_pkg::MONTH_W-1:0]          start_month;
  logic [dad_pkg::DAY_W-1:0]            start_day;
  logic signed [dad_pkg::OFFSET_BITS-1:0] day_offset;

  modport source (output valid, start_year, start_month, start_day, day_offset,
                  input ready);
  modport sink (input valid, start_year, start_month, start_day, day_offset,
                output ready);
endinterface

// ===== rtl/core/dad_out_if.sv =====
// Output channel of date_add_days_unit: valid/ready plus the resulting date.
// Depends on dad_pkg.
interface dad_out_if;
  logic                        valid;
  logic                        ready;
  logic [dad_pkg::YEAR_W-1:0]  end_year;
  logic [dad_pkg::MONTH_W-1:0] end_month;
  logic [dad_pkg::DAY_W-1:0]   end_day;
  logic                        year_out_of_range;

  modport source (output valid, end_year, end_month, end_day, year_out_of_range,
                  input ready);
  modport sink (input valid, end_year, end_month, end_day, year_out_of_range,
                output ready);
endinterface

// ===== rtl/core/dad_alu.sv =====
// Shared adder of the date walk with sign and positive flags.
// Depends on dad_pkg.
module dad_alu (
  input  logic [dad_pkg::ACC_W-1:0] a,
  input  logic [dad_pkg::ACC_W-1:0] b,
  output logic [dad_pkg::ACC_W-1:0] sum,
  output dad_pkg::dad_flags_t       flags
);

  assign sum        = a + b;
  assign flags.neg  = sum[dad_pkg::ACC_W-1];
  assign flags.plus = !sum[dad_pkg::ACC_W-1] && (sum != '0);

endmodule

// ===== rtl/core/dad_ctrl.sv =====
// Sequencer of the date walk: year-mod-400 reduction, then year and month
// steps through the shared adder. Depends on dad_pkg and dad_alu.
module dad_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  dad_pkg::dad_req_t req,
  input  dad_pkg::dad_cmd_t cmd,
  output dad_pkg::dad_ctl_t ctl,
  output dad_pkg::dad_res_t res
);

  localparam int AW = dad_pkg::ACC_W;
  localparam int YW = dad_pkg::WY_W;
  localparam int MW = dad_pkg::MONTH_W;
  localparam int CW = dad_pkg::Y400_W;

  dad_pkg::dad_state_t           state, state_next;
  logic [YW-1:0]                 wy, wy_next;
  logic [CW-1:0]                 y400, y400_next;
  logic [dad_pkg::YEAR_W-1:0]    modr, modr_next;
  logic [MW-1:0]                 month, month_next;
  logic [AW-1:0]                 acc, acc_next;

  logic [AW-1:0]        alu_a, alu_b, alu_sum;
  dad_pkg::dad_flags_t  flags;

  logic [MW-1:0] m_start, m_prev, m_succ;
  logic          leap_c, leap_p, leap_m, early;
  logic          fwd, big_fwd, big_bwd, off_plus, off_neg;
  logic [AW-1:0] yl_f, yl_b, ml_cur, ml_prev;

  dad_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sum   (alu_sum),
    .flags (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dad_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
    wy    <= wy_next;
    y400  <= y400_next;
    modr  <= modr_next;
    month <= month_next;
    acc   <= acc_next;
  end

  always_comb begin
    if (req.month == '0) begin
      m_start = MW'(1);
    end else if (req.month > MW'(dad_pkg::MONTHS)) begin
      m_start = MW'(dad_pkg::MONTHS);
    end else begin
      m_start = req.month;
    end
  end

  assign m_prev   = (month == MW'(1)) ? MW'(dad_pkg::MONTHS) : month - MW'(1);
  assign m_succ   = (month == MW'(dad_pkg::MONTHS)) ? MW'(1) : month + MW'(1);
  assign leap_c   = dad_pkg::is_leap(y400);
  assign leap_p   = dad_pkg::is_leap(dad_pkg::cyc_inc(y400));
  assign leap_m   = dad_pkg::is_leap(dad_pkg::cyc_dec(y400));
  assign early    = month <= MW'(dad_pkg::FEBRUARY);
  assign yl_f     = AW'(dad_pkg::SHORT_YEAR) + AW'(early ? leap_c : leap_p);
  assign yl_b     = AW'(dad_pkg::SHORT_YEAR) + AW'(early ? leap_m : leap_c);
  assign ml_cur   = AW'(dad_pkg::month_len(month, leap_c));
  assign ml_prev  = AW'(dad_pkg::month_len(m_prev, leap_c));
  assign fwd      = !acc[AW-1] && (acc != '0);
  assign big_fwd  = $signed(acc) > $signed(AW'(dad_pkg::LONG_YEAR));
  assign big_bwd  = $signed(acc) <= $signed(AW'(-dad_pkg::LONG_YEAR));
  assign off_neg  = req.offset[dad_pkg::OFFSET_BITS-1];
  assign off_plus = !off_neg && (req.offset != '0);

  always_comb begin
    state_next = state;
    wy_next    = wy;
    y400_next  = y400;
    modr_next  = modr;
    month_next = month;
    acc_next   = acc;
    alu_a      = acc;
    alu_b      = '0;
    ctl.idle   = (state == dad_pkg::ST_IDLE);
    ctl.done   = 1'b0;
    case (state)
      dad_pkg::ST_IDLE: begin
        alu_a = AW'(req.day);
        alu_b = AW'($signed(req.offset));
        if (cmd.start) begin
          wy_next    = YW'(req.year);
          modr_next  = req.year;
          month_next = m_start;
          acc_next   = alu_sum;
          if (off_plus || (off_neg && !flags.plus)) begin
            state_next = dad_pkg::ST_MOD;
          end else begin
            state_next = dad_pkg::ST_HOLD;
          end
        end
      end
      dad_pkg::ST_MOD: begin
        alu_a = AW'(modr);
        alu_b = AW'(-dad_pkg::CYCLE_YEARS);
        if (!flags.neg) begin
          modr_next = alu_sum[dad_pkg::YEAR_W-1:0];
        end else begin
          y400_next  = modr[CW-1:0];
          state_next = dad_pkg::ST_WALK;
        end
      end
      dad_pkg::ST_WALK: begin
        if (fwd) begin
          alu_b = big_fwd ? -yl_f : -ml_cur;
          if (flags.plus) begin
            acc_next = alu_sum;
            if (big_fwd || month == MW'(dad_pkg::MONTHS)) begin
              wy_next   = wy + YW'(1);
              y400_next = dad_pkg::cyc_inc(y400);
            end
            month_next = big_fwd ? month : m_succ;
          end else begin
            state_next = dad_pkg::ST_HOLD;
          end
        end else if (wy == '0) begin
          state_next = dad_pkg::ST_HOLD;
        end else begin
          alu_b    = big_bwd ? yl_b : ml_prev;
          acc_next = alu_sum;
          if (big_bwd || month == MW'(1)) begin
            wy_next   = wy - YW'(1);
            y400_next = dad_pkg::cyc_dec(y400);
          end
          month_next = big_bwd ? month : m_prev;
        end
      end
      dad_pkg::ST_HOLD: begin
        if (cmd.out_free) begin
          ctl.done   = 1'b1;
          state_next = dad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dad_pkg::ST_IDLE;
      end
    endcase
  end

  assign res.year  = wy;
  assign res.month = month;
  assign res.day   = acc[dad_pkg::DAY_W-1:0];

endmodule

// ===== rtl/core/date_add_days_unit.sv =====
// Adds a signed day count to a Gregorian date. An item is taken only while the
// unit is idle and then occupies it until its result is loaded into the output
// register. A zero offset, or a negative one that keeps the day at 1 or more,
// goes straight to the hold state. Otherwise the year is first reduced modulo 400
// by repeated subtraction, then one shared adder steps the day count by a whole
// year per cycle while more than a year remains and by one month per cycle after
// that. The output register lets the next item start while a result waits.
// Depends on dad_pkg, dad_in_if, dad_out_if and dad_ctrl.
module date_add_days_unit (
  input  logic      clk,
  input  logic      rst,
  dad_in_if.sink    operand,
  dad_out_if.source result
);

  localparam int YW = dad_pkg::WY_W;

  dad_pkg::dad_req_t req;
  dad_pkg::dad_cmd_t cmd;
  dad_pkg::dad_ctl_t ctl;
  dad_pkg::dad_res_t res;

  logic                        out_valid;
  logic [dad_pkg::YEAR_W-1:0]  out_year;
  logic [dad_pkg::MONTH_W-1:0] out_month;
  logic [dad_pkg::DAY_W-1:0]   out_day;
  logic                        out_flag;
  logic                        clamp_low, clamp_high;

  assign req.year   = operand.start_year;
  assign req.month  = operand.start_month;
  assign req.day    = operand.start_day;
  assign req.offset = operand.day_offset;

  assign cmd.start    = operand.valid && ctl.idle;
  assign cmd.out_free = !out_valid || result.ready;
  assign operand.ready = ctl.idle;

  dad_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .ctl (ctl),
    .res (res)
  );

  assign clamp_low  = (res.year < YW'(dad_pkg::YEAR_MIN));
  assign clamp_high = (res.year > YW'(dad_pkg::YEAR_MAX));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.done) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (ctl.done) begin
      if (clamp_low) begin
        out_year  <= dad_pkg::YEAR_W'(dad_pkg::YEAR_MIN);
        out_month <= dad_pkg::MONTH_W'(1);
        out_day   <= dad_pkg::DAY_W'(1);
      end else if (clamp_high) begin
        out_year  <= dad_pkg::YEAR_W'(dad_pkg::YEAR_MAX);
        out_month <= dad_pkg::MONTH_W'(dad_pkg::MONTHS);
        out_day   <= dad_pkg::DAY_W'(dad_pkg::LONG_MONTH);
      end else begin
        out_year  <= res.year[dad_pkg::YEAR_W-1:0];
        out_month <= res.month;
        out_day   <= res.day;
      end
      out_flag <= clamp_low || clamp_high;
    end
  end

  assign result.valid             = out_valid;
  assign result.end_year          = out_year;
  assign result.end_month         = out_month;
  assign result.end_day           = out_day;
  assign result.year_out_of_range = out_flag;

endmodule

// ===== rtl/core/dad_checker.sv =====
// Port-level checks for date_add_days_unit, attached by the bind at the end.
// Depends on dad_pkg and date_add_days_unit_defines.svh.
`include "date_add_days_unit_defines.svh"

module dad_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        op_valid,
  input logic                        op_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [dad_pkg::YEAR_W-1:0]  end_year,
  input logic [dad_pkg::MONTH_W-1:0] end_month,
  input logic [dad_pkg::DAY_W-1:0]   end_day,
  input logic                        year_out_of_range
);

  logic [dad_pkg::YEAR_W+dad_pkg::MONTH_W+dad_pkg::DAY_W:0] res_word;
  logic low_date, high_date, date_in_range;

  assign res_word = {end_year, end_month, end_day, year_out_of_range};
  assign low_date = end_year == dad_pkg::YEAR_W'(dad_pkg::YEAR_MIN) &&
                    end_month == dad_pkg::MONTH_W'(1) && end_day == dad_pkg::DAY_W'(1);
  assign high_date = end_year == dad_pkg::YEAR_W'(dad_pkg::YEAR_MAX) &&
                     end_month == dad_pkg::MONTH_W'(dad_pkg::MONTHS) &&
                     end_day == dad_pkg::DAY_W'(dad_pkg::LONG_MONTH);
  assign date_in_range = end_year >= dad_pkg::YEAR_W'(dad_pkg::YEAR_MIN) &&
                         end_year <= dad_pkg::YEAR_W'(dad_pkg::YEAR_MAX) &&
                         end_month >= dad_pkg::MONTH_W'(1) &&
                         end_month <= dad_pkg::MONTH_W'(dad_pkg::MONTHS);

  // The unit works on one item at a time, so an input transfer makes it busy.
  `DAD_ASSERT_NEXT(a_busy_after_accept, op_valid && op_ready, !op_ready)
  `DAD_ASSERT_NEXT(a_result_holds, res_valid && !res_ready, res_valid && $stable(res_word))
  `DAD_ASSERT_IMPLY(a_clamped_date, res_valid && year_out_of_range, low_date || high_date)
  `DAD_ASSERT_IMPLY(a_result_range, res_valid, date_in_range)
  `DAD_ASSERT_RESET(a_reset_clears, rst, !res_valid)

endmodule

bind date_add_days_unit dad_checker u_dad_checker (
  .clk               (clk),
  .rst               (rst),
  .op_valid          (operand.valid),
  .op_ready          (operand.ready),
  .res_valid         (result.valid),
  .res_ready         (result.ready),
  .end_year          (result.end_year),
  .end_month         (result.end_month),
  .end_day           (result.end_day),
  .year_out_of_range (result.year_out_of_range)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for date_add_days_unit: directed and random dates with
// signed day offsets, checked against an in-bench calendar predictor.
// Depends on dad_pkg, dad_in_if, dad_out_if and date_add_days_unit.
module tb_top;

  localparam int YW = dad_pkg::YEAR_W;
  localparam int MW = dad_pkg::MONTH_W;
  localparam int DW = dad_pkg::DAY_W;
  localparam int OW = dad_pkg::OFFSET_BITS;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_ITEMS  = 300;
  localparam int PRINT_LIMIT  = 100;

  typedef struct {
    logic [YW-1:0] year;
    logic [MW-1:0] month;
    logic [DW-1:0] day;
    logic          out_of_range;
  } date_answer_t;

  class date_scoreboard;
    date_answer_t answer_q[$];
    int errors;
    int requests;
    int results;
    int clamped;

    function new();
      errors = 0;
      requests = 0;
      results = 0;
      clamped = 0;
    endfunction

    task report(string msg);
      if (errors < PRINT_LIMIT) $display("ERROR: result %0d: %s", results, msg);
      errors++;
    endtask

    function longint day_serial(longint y, longint m, longint d);
      longint era, yoe, mp, doy, doe;
      if (m <= dad_pkg::FEBRUARY) y = y - 1;
      era = (y >= 0 ? y : y - (dad_pkg::CYCLE_YEARS - 1)) / dad_pkg::CYCLE_YEARS;
      yoe = y - era * dad_pkg::CYCLE_YEARS;
      mp = (m + 9) % dad_pkg::MONTHS;
      doy = (153 * mp + 2) / 5 + d - 1;
      doe = yoe * dad_pkg::SHORT_YEAR + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
    endfunction

    function void serial_to_date(longint z, output longint y, output longint m,
                                 output longint d);
      longint era, doe, yoe, doy, mp;
      z = z + 719468;
      era = (z >= 0 ? z : z - 146096) / 146097;
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / dad_pkg::SHORT_YEAR;
      doy = doe - (dad_pkg::SHORT_YEAR * yoe + yoe / 4 - yoe / 100);
      mp = (5 * doy + 2) / 153;
      d = doy - (153 * mp + 2) / 5 + 1;
      m = mp < 10 ? mp + 3 : mp - 9;
      y = yoe + era * dad_pkg::CYCLE_YEARS + (m <= dad_pkg::FEBRUARY ? 1 : 0);
    endfunction

    function date_answer_t shift_date(logic [YW-1:0] y_in, logic [MW-1:0] m_in,
                                      logic [DW-1:0] d_in, logic signed [OW-1:0] off_in);
      longint y, m, d, off;
      date_answer_t a;
      y = y_in;
      m = m_in;
      d = d_in;
      off = off_in;
      a.out_of_range = 1'b0;
      if (m < 1) m = 1;
      if (m > dad_pkg::MONTHS) m = dad_pkg::MONTHS;
      if (off > 0 || (off < 0 && d + off <= 0))
        serial_to_date(day_serial(y, m, d + off), y, m, d);
      else
        d = d + off;
      if (y < dad_pkg::YEAR_MIN) begin
        y = dad_pkg::YEAR_MIN;
        m = 1;
        d = 1;
        a.out_of_range = 1'b1;
      end else if (y > dad_pkg::YEAR_MAX) begin
        y = dad_pkg::YEAR_MAX;
        m = dad_pkg::MONTHS;
        d = dad_pkg::LONG_MONTH;
        a.out_of_range = 1'b1;
      end
      a.year = y[YW-1:0];
      a.month = m[MW-1:0];
      a.day = d[DW-1:0];
      return a;
    endfunction

    function void note_request(logic [YW-1:0] y, logic [MW-1:0] m,
                               logic [DW-1:0] d, logic signed [OW-1:0] off);
      date_answer_t a;
      a = shift_date(y, m, d, off);
      if (a.out_of_range) clamped++;
      answer_q.push_back(a);
      requests++;
    endfunction

    task check_result(logic [YW-1:0] y, logic [MW-1:0] m, logic [DW-1:0] d,
                      logic flag);
      date_answer_t a;
      if (answer_q.size() == 0) begin
        report("result transfer with no request outstanding");
      end else begin
        a = answer_q.pop_front();
        if (y !== a.year) report($sformatf("end_year %0d, predicted %0d", y, a.year));
        if (m !== a.month) report($sformatf("end_month %0d, predicted %0d", m, a.month));
        if (d !== a.day) report($sformatf("end_day %0d, predicted %0d", d, a.day));
        if (flag !== a.out_of_range)
          report($sformatf("year_out_of_range %0b, predicted %0b", flag, a.out_of_range));
      end
      results++;
    endtask

    function int pending();
      return answer_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic out_hold;
  int   in_idle_pct;
  int   out_stall_pct;
  int   cycle_count = 0;
  event start_hold;
  date_scoreboard sb;

  dad_in_if  date_in ();
  dad_out_if date_out ();

  date_add_days_unit dut (
    .clk    (clk),
    .rst    (rst),
    .operand(date_in),
    .result (date_out)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               sb.pending());
      $display("date_add_days_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && date_in.valid && date_in.ready)
      sb.note_request(date_in.start_year, date_in.start_month, date_in.start_day,
                      date_in.day_offset);
    if (!rst && date_out.valid && date_out.ready)
      sb.check_result(date_out.end_year, date_out.end_month, date_out.end_day,
                      date_out.year_out_of_range);
  end

  initial begin
    out_hold = 1'b0;
    forever begin
      @(start_hold);
      out_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_hold = 1'b0;
    end
  end

  initial begin
    date_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      date_out.ready <= !out_hold && ($urandom_range(99) >= out_stall_pct);
    end
  end

  function automatic int month_days(int y, int m);
    bit leap;
    leap = (y % 4 == 0 && y % 100 != 0) || (y % dad_pkg::CYCLE_YEARS == 0);
    if (m == dad_pkg::FEBRUARY) return leap ? dad_pkg::FEB_LEAP : dad_pkg::FEB_SHORT;
    if (m == 4 || m == 6 || m == 9 || m == 11) return dad_pkg::SHORT_MONTH;
    return dad_pkg::LONG_MONTH;
  endfunction

  task automatic send_date(input int y, input int m, input int d, input int off);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      date_in.valid <= 1'b0;
      @(negedge clk);
    end
    date_in.valid       <= 1'b1;
    date_in.start_year  <= YW'(y);
    date_in.start_month <= MW'(m);
    date_in.start_day   <= DW'(d);
    date_in.day_offset  <= OW'(off);
    do @(posedge clk); while (date_in.ready !== 1'b1);
  endtask

  task automatic send_random_date();
    int y, m, d, off, kind;
    kind = $urandom_range(99);
    if (kind < 10) begin
      y = $urandom_range(0, (1 << YW) - 1);
      m = $urandom_range(0, (1 << MW) - 1);
      d = $urandom_range(0, (1 << DW) - 1);
      off = int'($urandom);
    end else begin
      if (kind < 16 && $urandom_range(1) == 0) y = $urandom_range(dad_pkg::YEAR_MIN, 3);
      else if (kind < 16) y = $urandom_range(dad_pkg::YEAR_MAX - 2, dad_pkg::YEAR_MAX);
      else y = $urandom_range(dad_pkg::YEAR_MIN, dad_pkg::YEAR_MAX);
      m = $urandom_range(1, dad_pkg::MONTHS);
      d = $urandom_range(1, month_days(y, m));
      case ($urandom_range(3))
        0, 1: off = int'($urandom_range(0, 80)) - 40;
        2: off = int'($urandom_range(0, 6000)) - 3000;
        default: off = int'($urandom);
      endcase
    end
    send_date(y, m, d, off);
  endtask

  int phase_in_idle[4]   = '{0, 84, 0, 6};
  int phase_out_stall[4] = '{0, 0, 84, 6};

  initial begin
    sb = new();
    rst = 1'b1;
    in_idle_pct = 0;
    out_stall_pct = 0;
    date_in.valid = 1'b0;
    date_in.start_year = '0;
    date_in.start_month = '0;
    date_in.start_day = '0;
    date_in.day_offset = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_date(2024, 2, 29, 0);
    send_date(2023, 0, 15, 0);
    send_date(2023, 15, 31, 0);
    send_date(2023, 2, 31, 1);
    send_date(2023, 2, 31, -1);
    send_date(2023, 3, 0, 1);
    send_date(2023, 3, 0, -1);
    send_date(2023, 3, 0, 0);
    send_date(1900, 2, 28, 1);
    send_date(2000, 2, 28, 1);
    send_date(2024, 3, 1, -1);
    send_date(1999, 12, 31, 1);
    send_date(2000, 1, 1, -1);
    send_date(9999, 12, 31, 65535);
    send_date(1, 1, 1, -65536);
    send_date(1, 1, 1, 65535);
    send_date(9999, 1, 1, -65536);
    send_date(9999, 12, 31, 1);
    send_date(1, 1, 1, -1);
    send_date(0, 6, 10, 0);
    send_date(0, 12, 31, 1);
    send_date(16383, 7, 4, -65536);
    send_date(10180, 0, 0, -65536);
    send_date(5000, 12, 31, 32767);

    for (int p = 0; p < 4; p++) begin
      in_idle_pct = phase_in_idle[p];
      out_stall_pct = phase_out_stall[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 0 && i == PHASE_ITEMS / 2) -> start_hold;
        send_random_date();
      end
    end

    @(negedge clk);
    date_in.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input transfers and %0d checked results, %0d of them clamped,",
             sb.requests, sb.results, sb.clamped);
    $display("across four idle/stall mixes and one %0d-cycle output hold.", HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("date_add_days_unit: match");
    end else begin
      $display("%0d errors found.", sb.errors);
      $display("date_add_days_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dad_pkg.sv
rtl/core/dad_in_if.sv
rtl/core/dad_out_if.sv
rtl/core/dad_alu.sv
rtl/core/dad_ctrl.sv
rtl/core/date_add_days_unit.sv
rtl/core/dad_checker.sv
tb/sv/tb_top.sv
